[rtl/bezier_curve_point_evaluator_macros.svh]
// Assertion macros for the Bezier curve point evaluator checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BEZIER_CURVE_POINT_EVALUATOR_MACROS_SVH
`define BEZIER_CURVE_POINT_EVALUATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BCPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BCPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bcpe_pkg.sv]
// Shared constants and types for the Bezier curve point evaluator.
// No dependencies; imported by the lerp unit, the top level and the checker.
package bcpe_pkg;

    // Three coordinates per point, packed x lowest.
    localparam int NUM_COORDS = 3;

    // Width of the point count field in a result beat.
    localparam int COUNT_FIELD_W = 5;

    typedef logic [1:0] coord_idx_t;

    localparam coord_idx_t COORD_X = 2'd0;
    localparam coord_idx_t COORD_Z = 2'd2;

endpackage

[rtl/bcpe_ram.sv]
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies; holds the control point store of the evaluator.
module bcpe_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/bcpe_lerp_unit.sv]
// Shared interpolation unit: p + round((q - p) * t / 2^T_FRAC_BITS) for x, y, z.
// One subtractor, one multiplier and one adder, pipelined over the coordinates.
// Depends on bcpe_pkg.
module bcpe_lerp_unit import bcpe_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [T_FRAC_BITS:0]              t_frac,
    input  logic [NUM_COORDS*COORD_WIDTH-1:0] p_pt,
    input  logic [NUM_COORDS*COORD_WIDTH-1:0] q_pt,
    output logic [NUM_COORDS*COORD_WIDTH-1:0] r_pt,
    output logic                              done
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = CW + T_FRAC_BITS + 3;

    logic [NUM_COORDS*CW-1:0] p_reg;
    logic [NUM_COORDS*CW-1:0] q_reg;
    logic [T_FRAC_BITS:0]     t_reg;

    logic       iss_vld_reg;
    coord_idx_t iss_idx_reg;
    logic       d_vld_reg;
    coord_idx_t d_idx_reg;
    logic       m_vld_reg;
    coord_idx_t m_idx_reg;
    logic       done_reg;

    logic signed [CW:0]   diff_reg;
    logic signed [PW-1:0] prod_reg;
    logic [CW-1:0]        res_reg [NUM_COORDS];

    logic [CW-1:0]          p_iss;
    logic [CW-1:0]          q_iss;
    logic [CW-1:0]          p_add;
    logic signed [T_FRAC_BITS+1:0] t_s;
    logic signed [CW+2:0]   sum;

    assign p_iss = p_reg[iss_idx_reg*CW +: CW];
    assign q_iss = q_reg[iss_idx_reg*CW +: CW];
    assign p_add = p_reg[m_idx_reg*CW +: CW];
    assign t_s   = {1'b0, t_reg};

    // The rounding half is folded in as a carry: floor((x + 2^(F-1)) / 2^F)
    // equals floor(x / 2^F) plus bit F-1 of x.
    assign sum = {{3{p_add[CW-1]}}, p_add}
               + prod_reg[PW-1:T_FRAC_BITS]
               + {{(CW+2){1'b0}}, prod_reg[T_FRAC_BITS-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_vld_reg <= 1'b0;
            iss_idx_reg <= COORD_X;
            d_vld_reg   <= 1'b0;
            d_idx_reg   <= COORD_X;
            m_vld_reg   <= 1'b0;
            m_idx_reg   <= COORD_X;
            done_reg    <= 1'b0;
        end else begin
            if (start) begin
                iss_vld_reg <= 1'b1;
                iss_idx_reg <= COORD_X;
            end else if (iss_vld_reg) begin
                iss_vld_reg <= (iss_idx_reg != COORD_Z);
                iss_idx_reg <= iss_idx_reg + 2'd1;
            end
            d_vld_reg <= iss_vld_reg;
            d_idx_reg <= iss_idx_reg;
            m_vld_reg <= d_vld_reg;
            m_idx_reg <= d_idx_reg;
            done_reg  <= m_vld_reg && (m_idx_reg == COORD_Z);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            p_reg <= p_pt;
            q_reg <= q_pt;
            t_reg <= t_frac;
        end
        diff_reg <= $signed({q_iss[CW-1], q_iss}) - $signed({p_iss[CW-1], p_iss});
        prod_reg <= diff_reg * t_s;
        if (m_vld_reg) begin
            res_reg[m_idx_reg] <= sum[CW-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_COORDS; k++) begin
            r_pt[k*CW +: CW] = res_reg[k];
        end
    end

    assign done = done_reg;

endmodule

[rtl/bezier_curve_point_evaluator.sv]
// Top level of the Bezier curve point evaluator (de Casteljau).
// Depends on bcpe_pkg, bcpe_ram and bcpe_lerp_unit.
//
//  Channel | Direction | tdata (lowest bit up)                   | tlast      | tuser
//  s_      | in        | point_x, point_y, point_z, t_frac       | last_point | -
//  m_      | out       | curve_x, curve_y, curve_z, point_count  | -          | points_dropped
//
// Loading takes one cycle per control point beat. The beat with tlast starts the
// evaluation, which runs N * (N - 1) / 2 interpolation steps for N stored points:
// each step is a store read (ST_RD, ST_WT) followed by a pass through the shared
// lerp unit, whose single multiplier works through x, y and z in turn.
// s_tready is low from the last beat until the result beat has been taken.
// Reset is synchronous and empties the store; no clearing pass is needed.
module bezier_curve_point_evaluator import bcpe_pkg::*; #(
    parameter int MAX_POINTS  = 16,
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16,
    localparam int S_TDATA_W = ((NUM_COORDS*COORD_WIDTH + T_FRAC_BITS + 1 + 7) / 8) * 8,
    localparam int M_TDATA_W = ((NUM_COORDS*COORD_WIDTH + COUNT_FIELD_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // point_x, point_y, point_z, t_frac
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // curve_x, curve_y, curve_z, point_count
    output logic [M_TDATA_W-1:0] m_tdata,
    // points_dropped
    output logic                 m_tuser
);

    localparam int CW     = COORD_WIDTH;
    localparam int PT_W   = NUM_COORDS * CW;
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    typedef enum logic [6:0] {
        ST_LOAD = 7'b0000001,
        ST_RD   = 7'b0000010,
        ST_WT   = 7'b0000100,
        ST_CALC = 7'b0001000,
        ST_FRD  = 7'b0010000,
        ST_FWT  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [T_FRAC_BITS:0] t_reg, t_next;
    logic [ADDR_W-1:0]   level_reg, level_next;
    logic [ADDR_W-1:0]   j_reg, j_next;
    logic [PT_W-1:0]     curve_reg;
    logic [CNT_W-1:0]    cnt_out_reg;
    logic                drop_out_reg;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [PT_W-1:0]      ram_wdata;
    logic [PT_W-1:0]      rdata_a, rdata_b;
    logic [PT_W-1:0]      lerp_res;
    logic                 lerp_start, lerp_done;
    logic [T_FRAC_BITS:0] t_in;
    logic                 store_full;
    logic [CNT_W-1:0]     count_inc;
    logic                 s_beat;

    assign s_beat     = s_tvalid && s_tready;
    assign t_in       = s_tdata[PT_W +: T_FRAC_BITS+1];
    assign store_full = (count_reg >= CNT_W'(MAX_POINTS));
    assign count_inc  = store_full ? count_reg : count_reg + CNT_W'(1);

    bcpe_ram #(
        .WIDTH(PT_W),
        .DEPTH(MAX_POINTS)
    ) u_store (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (j_reg),
        .raddr_b (j_reg + ADDR_W'(1)),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    bcpe_lerp_unit #(
        .COORD_WIDTH(COORD_WIDTH),
        .T_FRAC_BITS(T_FRAC_BITS)
    ) u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lerp_start),
        .t_frac  (t_reg),
        .p_pt    (rdata_a),
        .q_pt    (rdata_b),
        .r_pt    (lerp_res),
        .done    (lerp_done)
    );

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        t_next     = t_reg;
        level_next = level_reg;
        j_next     = j_reg;
        ram_we     = 1'b0;
        ram_waddr  = j_reg;
        ram_wdata  = lerp_res;
        lerp_start = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready  = 1'b1;
                ram_waddr = count_reg[ADDR_W-1:0];
                ram_wdata = s_tdata[PT_W-1:0];
                if (s_tvalid) begin
                    ram_we     = !store_full;
                    ovf_next   = ovf_reg || store_full;
                    count_next = count_inc;
                    if (s_tlast) begin
                        t_next     = (t_in > T_ONE) ? T_ONE : t_in;
                        j_next     = '0;
                        level_next = ADDR_W'(count_inc - CNT_W'(1));
                        // A single point needs no interpolation at all.
                        state_next = (count_inc == CNT_W'(1)) ? ST_FRD : ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_WT;
            end
            ST_WT: begin
                lerp_start = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (lerp_done) begin
                    ram_we = 1'b1;
                    if (j_reg == level_reg - ADDR_W'(1)) begin
                        j_next = '0;
                        if (level_reg == ADDR_W'(1)) begin
                            state_next = ST_FRD;
                        end else begin
                            level_next = level_reg - ADDR_W'(1);
                            state_next = ST_RD;
                        end
                    end else begin
                        j_next     = j_reg + ADDR_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_FRD: begin
                state_next = ST_FWT;
            end
            ST_FWT: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg     <= t_next;
        level_reg <= level_next;
        j_reg     <= j_next;
        if (state_reg == ST_FWT) begin
            curve_reg    <= rdata_a;
            cnt_out_reg  <= count_reg;
            drop_out_reg <= ovf_reg;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = M_TDATA_W'({COUNT_FIELD_W'(cnt_out_reg), curve_reg});
    assign m_tuser  = drop_out_reg;

endmodule

[rtl/bcpe_checker.sv]
// Port-level checker for the Bezier curve point evaluator, bound to the top level.
// Depends on bcpe_pkg and bezier_curve_point_evaluator_macros.svh.
`include "bezier_curve_point_evaluator_macros.svh"

module bcpe_checker import bcpe_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16,
    localparam int S_TDATA_W = ((NUM_COORDS*COORD_WIDTH + T_FRAC_BITS + 1 + 7) / 8) * 8,
    localparam int M_TDATA_W = ((NUM_COORDS*COORD_WIDTH + COUNT_FIELD_W + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // A stalled result beat keeps its contents.
    `BCPE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // Only one curve is in flight: no input is taken while a result waits.
    `BCPE_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready, "input ready while a result is pending")

    // The closing beat of a curve stops further input until the result has gone.
    `BCPE_ASSERT_NXT(a_last_stalls, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready && !m_tvalid, "input not held off after the last point")

    // Each curve yields exactly one result beat.
    `BCPE_ASSERT_NXT(a_one_result, aclk, aresetn, m_tvalid && m_tready, !m_tvalid && s_tready, "more than one result beat for a curve")

endmodule

bind bezier_curve_point_evaluator bcpe_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .T_FRAC_BITS(T_FRAC_BITS)
) u_bcpe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
